// ===== rtl/i2cmbw_pkg.sv =====
// shared types and codes for the i2c master byte writer
package i2cmbw_pkg;

    // operation codes carried in the mode field
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STOP  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;
    localparam logic [1:0] MODE_PROBE = 2'd3;

    localparam int HOLD_W = 16;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd288;

    // one requested bus operation
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
        logic       ack_level;
    } t_in;

    // one settled line segment
    typedef struct packed {
        logic scl;
        logic sda_drive;
        logic sda_out;
        logic hold;
        logic ack;
        logic last;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture byte and ack level of a new operation
        logic emit;       // write one segment into the output register
        logic scl;        // clock level of the segment
        logic scl_keep;   // keep the present clock level instead
        logic sda_drive;
        logic sda;        // fixed data level
        logic sda_data;   // take data level from the shift register msb
        logic hold;
        logic last;
        logic ack_en;     // report the captured acknowledge level on this segment
        logic shift;      // move to the next data bit
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free;  // output register empty and no line hold running
    } t_sts;

endpackage

// ===== rtl/i2cmbw_ctrl.sv =====
// segment sequencer state machine for the i2c master byte writer
module i2cmbw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_mode,
    output logic               o_in_ready,
    input  i2cmbw_pkg::t_sts   i_sts,
    output i2cmbw_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_BIT   = 3'd2;
    localparam logic [2:0] S_ACK   = 3'd3;
    localparam logic [2:0] S_STOP  = 3'd4;

    localparam logic [1:0] STEP_LAST = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_step, n_step;
    logic [2:0] r_bit, n_bit;
    logic [1:0] r_mode, n_mode;
    logic       w_end;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_end      = (r_step == STEP_LAST);

    // segment selection and sequencing
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        n_mode  = r_mode;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    n_step     = 2'd0;
                    n_bit      = 3'd0;
                    case (i_mode)
                        i2cmbw_pkg::MODE_START: n_state = S_START;
                        i2cmbw_pkg::MODE_STOP:  n_state = S_STOP;
                        i2cmbw_pkg::MODE_WRITE: n_state = S_BIT;
                        i2cmbw_pkg::MODE_PROBE: n_state = S_START;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_START: begin
                o_cmd.scl       = !w_end;
                o_cmd.sda_drive = 1'b1;
                o_cmd.sda       = (r_step == 2'd0);
                o_cmd.hold      = !w_end;
                o_cmd.last      = w_end && (r_mode == i2cmbw_pkg::MODE_START);
            end
            S_BIT: begin
                o_cmd.scl_keep  = (r_step == 2'd0);
                o_cmd.scl       = (r_step == 2'd1);
                o_cmd.sda_drive = 1'b1;
                o_cmd.sda_data  = 1'b1;
                o_cmd.hold      = !w_end;
            end
            S_ACK: begin
                o_cmd.scl       = (r_step == 2'd1);
                o_cmd.sda       = 1'b1;
                o_cmd.hold      = !w_end;
                o_cmd.last      = w_end && (r_mode == i2cmbw_pkg::MODE_WRITE);
                o_cmd.ack_en    = o_cmd.last;
            end
            S_STOP: begin
                o_cmd.scl       = (r_step != 2'd0);
                o_cmd.sda_drive = 1'b1;
                o_cmd.sda       = w_end;
                o_cmd.hold      = 1'b1;
                o_cmd.last      = w_end;
                o_cmd.ack_en    = w_end && (r_mode == i2cmbw_pkg::MODE_PROBE);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance one segment whenever the output side can take it
        if (r_state != S_IDLE && i_sts.slot_free) begin
            o_cmd.emit  = 1'b1;
            o_cmd.shift = (r_state == S_BIT) && w_end;
            if (!w_end) begin
                n_step = r_step + 2'd1;
            end else begin
                n_step = 2'd0;
                case (r_state)
                    S_START: n_state = (r_mode == i2cmbw_pkg::MODE_PROBE) ? S_BIT : S_IDLE;
                    S_BIT: begin
                        n_bit = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            n_state = S_ACK;
                        end
                    end
                    S_ACK:   n_state = (r_mode == i2cmbw_pkg::MODE_PROBE) ? S_STOP : S_IDLE;
                    default: n_state = S_IDLE;
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 2'd0;
            r_bit   <= 3'd0;
            r_mode  <= i2cmbw_pkg::MODE_START;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_mode  <= n_mode;
        end
    end

endmodule

// ===== rtl/i2cmbw_dp.sv =====
// datapath: byte shifter, clock line level, output register and hold timer
module i2cmbw_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_mode,
    input  logic [7:0]                      i_data,
    input  logic                            i_ack_level,
    input  logic                            i_cfg_we,
    input  logic [i2cmbw_pkg::HOLD_W-1:0]   i_cfg_wdata,
    input  i2cmbw_pkg::t_cmd                i_cmd,
    output i2cmbw_pkg::t_sts                o_sts,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output i2cmbw_pkg::t_out                o_out_data
);

    logic [i2cmbw_pkg::HOLD_W-1:0] r_hold_cycles;
    logic [i2cmbw_pkg::HOLD_W-1:0] r_wait;
    logic [7:0]                    r_shift;
    logic                          r_ack;
    logic                          r_clock_line;
    logic                          r_out_valid;
    i2cmbw_pkg::t_out              r_out;
    i2cmbw_pkg::t_out              w_seg;

    assign o_sts.slot_free = !r_out_valid && (r_wait == '0);
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

    // assemble the segment the controller asks for
    always_comb begin
        w_seg.scl       = i_cmd.scl_keep ? r_clock_line : i_cmd.scl;
        w_seg.sda_drive = i_cmd.sda_drive;
        w_seg.sda_out   = i_cmd.sda_data ? r_shift[7] : i_cmd.sda;
        w_seg.hold      = i_cmd.hold;
        w_seg.ack       = i_cmd.ack_en & r_ack;
        w_seg.last      = i_cmd.last;
    end

    // configuration, line state and hold timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cycles <= i2cmbw_pkg::HOLD_RESET;
            r_wait        <= '0;
            r_clock_line  <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hold_cycles <= i_cfg_wdata;
            end
            if (i_cmd.emit) begin
                r_clock_line <= w_seg.scl;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // a held segment loads the hold timer from hold_cycles at its transfer
            if (r_out_valid && i_out_ready && r_out.hold) begin
                r_wait <= r_hold_cycles;
            end else if (r_wait != '0) begin
                r_wait <= r_wait - {{(i2cmbw_pkg::HOLD_W-1){1'b0}}, 1'b1};
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift <= (i_mode == i2cmbw_pkg::MODE_PROBE) ? {i_data[6:0], 1'b0} : i_data;
            r_ack   <= i_ack_level;
        end else if (i_cmd.shift) begin
            r_shift <= {r_shift[6:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_out <= w_seg;
        end
    end

endmodule

// ===== rtl/i2c_master_byte_writer_core.sv =====
// i2c master byte writer: top level joining sequencer and datapath
//
// Input channel (i_in_valid / o_in_ready, i_in_data) takes one bus operation
// per transfer: start, stop, write byte with acknowledge, or address probe.
// Output channel (o_out_valid / i_out_ready, o_out_data) gives the run of
// line segments of that operation, the final one flagged by last and, for a
// write or probe, carrying the operation's acknowledge level (0 = acknowledged).
// i_cfg_we / i_cfg_wdata set hold_cycles, the length of one line hold.
// Each segment is emitted into the output register and then transferred, and a
// segment with hold set is followed by a line hold counted from its transfer,
// so the length of an operation grows with its number of segments and with
// hold_cycles for each held segment.
// The hold timer sets the rate; one operation is in flight at a time and
// the next is taken once the last segment has been emitted.
// A stalled receiver holds the output register; sequencing and the hold
// timer wait on it. Reset empties the output, sets hold_cycles to 288 and
// leaves the clock line idle high.
module i2c_master_byte_writer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  i2cmbw_pkg::t_in                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output i2cmbw_pkg::t_out                o_out_data,
    input  logic                            i_cfg_we,
    input  logic [i2cmbw_pkg::HOLD_W-1:0]   i_cfg_wdata
);

    i2cmbw_pkg::t_cmd w_cmd;
    i2cmbw_pkg::t_sts w_sts;

    // operation sequencer
    i2cmbw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // segment datapath
    i2cmbw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (i_in_data.mode),
        .i_data      (i_in_data.data),
        .i_ack_level (i_in_data.ack_level),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/i2cmbw_checker.sv =====
// port-level checks for the i2c master byte writer
module i2cmbw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input i2cmbw_pkg::t_out                o_out_data
);

    // a stalled segment stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled segment keeps its payload
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // one operation at a time: ready falls after an input transfer
    a_in_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

    // acknowledge only reported on the final segment
    a_ack_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.ack |-> o_out_data.last)
        else $error("ack set on a non-final segment");

    // output valid drops after each segment transfer
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready |=> !o_out_valid)
        else $error("segments issued back to back");

endmodule

bind i2c_master_byte_writer_core i2cmbw_checker u_i2cmbw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== sim/i2c_master_byte_writer_core_tb.sv =====
// testbench for the i2c master byte writer core: line segment sequences checked per transfer
`timescale 1ns / 100ps

module i2c_master_byte_writer_core_tb;

    localparam longint TIMEOUT_NS = 4_000_000;
    localparam int     MAX_PRINTS = 40;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    i2cmbw_pkg::t_in               in_item   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    i2cmbw_pkg::t_out              out_seg;
    logic                          cfg_we    = 1'b0;
    logic [i2cmbw_pkg::HOLD_W-1:0] cfg_wdata = '0;

    // expected line segments, oldest first
    i2cmbw_pkg::t_out              line_seg_q[$];
    logic [i2cmbw_pkg::HOLD_W-1:0] hold_setting = i2cmbw_pkg::HOLD_RESET;
    bit                tail_hold    = 1'b0;
    bit                idle_on      = 1'b1;
    int                stall_left   = 0;
    int                ops_sent     = 0;
    int                seg_seen     = 0;
    int                error_count  = 0;

    // predicted bus line state
    logic bus_scl   = 1'b1;
    logic bus_sda   = 1'b1;
    logic bus_drive = 1'b1;

    i2c_master_byte_writer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_seg),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // give up after a generous fixed time
    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------- line segment predictor ----------------

    function automatic void put_seg(input logic hold);
        i2cmbw_pkg::t_out s;
        s           = '0;
        s.scl       = bus_scl;
        s.sda_drive = bus_drive;
        s.sda_out   = bus_sda;
        s.hold      = hold;
        line_seg_q.push_back(s);
    endfunction

    function automatic void seq_start();
        bus_drive = 1'b1;
        bus_sda   = 1'b1;
        bus_scl   = 1'b1;
        put_seg(1'b1);
        bus_sda = 1'b0;
        put_seg(1'b1);
        bus_scl = 1'b0;
        put_seg(1'b0);
    endfunction

    // sda rises only after scl has been high for one hold
    function automatic void seq_stop();
        bus_drive = 1'b1;
        bus_scl   = 1'b0;
        bus_sda   = 1'b0;
        put_seg(1'b1);
        bus_scl = 1'b1;
        put_seg(1'b1);
        bus_sda = 1'b1;
        put_seg(1'b1);
    endfunction

    // eight bits msb first, first segment keeps the present clock level
    function automatic void seq_write(input logic [7:0] b);
        bus_drive = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            bus_sda = b[i];
            put_seg(1'b1);
            bus_scl = 1'b1;
            put_seg(1'b1);
            bus_scl = 1'b0;
            put_seg(1'b0);
        end
        // release sda for the acknowledge clock
        bus_drive = 1'b0;
        bus_sda   = 1'b1;
        put_seg(1'b1);
        bus_scl = 1'b1;
        put_seg(1'b1);
        bus_scl = 1'b0;
        put_seg(1'b0);
    endfunction

    function automatic void predict_line_segments(input i2cmbw_pkg::t_in op);
        i2cmbw_pkg::t_out s;
        case (op.mode)
            i2cmbw_pkg::MODE_START: seq_start();
            i2cmbw_pkg::MODE_STOP:  seq_stop();
            i2cmbw_pkg::MODE_WRITE: seq_write(op.data);
            i2cmbw_pkg::MODE_PROBE: begin
                // address bit seven falls off the shifted byte
                seq_start();
                seq_write({op.data[6:0], 1'b0});
                seq_stop();
            end
            default: ;
        endcase
        s = line_seg_q.pop_back();
        if (op.mode inside {i2cmbw_pkg::MODE_WRITE, i2cmbw_pkg::MODE_PROBE})
            s.ack = op.ack_level;
        s.last = 1'b1;
        line_seg_q.push_back(s);
    endfunction

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_error($sformatf("segment %0d %s got %b expected %b", seg_seen, name, got, want));
    endtask

    // compare each accepted segment with the oldest expectation
    always @(posedge clk) begin : seg_check
        i2cmbw_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            seg_seen++;
            if (line_seg_q.size() == 0) begin
                report_error($sformatf("segment %0d arrived with nothing pending", seg_seen));
            end else begin
                want = line_seg_q.pop_front();
                check_field("scl", out_seg.scl, want.scl);
                check_field("sda_drive", out_seg.sda_drive, want.sda_drive);
                check_field("sda_out", out_seg.sda_out, want.sda_out);
                check_field("hold", out_seg.hold, want.hold);
                check_field("ack", out_seg.ack, want.ack);
                check_field("last", out_seg.last, want.last);
                tail_hold = out_seg.hold;
            end
        end
    end

    // receiver side: random stall bursts while idling is enabled
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ---------------- stimulus helpers ----------------

    function automatic i2cmbw_pkg::t_in make_op(input logic [1:0] m, input logic [7:0] d,
                                                input logic a);
        i2cmbw_pkg::t_in op;
        op.mode      = m;
        op.data      = d;
        op.ack_level = a;
        return op;
    endfunction

    // one operation transfer; valid stays up so the next call can follow at once
    task automatic send_op(input i2cmbw_pkg::t_in op);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge clk); while (!in_ready);
        predict_line_segments(op);
        ops_sent++;
    endtask

    // drop valid, let every segment arrive and any trailing hold run out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (line_seg_q.size() != 0) @(posedge clk);
        repeat ((tail_hold ? int'(hold_setting) : 0) + 16) @(posedge clk);
    endtask

    task automatic set_hold(input logic [i2cmbw_pkg::HOLD_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we       <= 1'b0;
        hold_setting = v;
    endtask

    task automatic send_transaction(input int n_bytes);
        send_op(make_op(i2cmbw_pkg::MODE_START, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
        repeat (n_bytes)
            send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1))));
        send_op(make_op(i2cmbw_pkg::MODE_STOP, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
    endtask

    // ---------------- tests ----------------

    // every operation at the reset hold length
    task automatic test_default_hold();
        send_op(make_op(i2cmbw_pkg::MODE_START, 8'h00, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'hA5, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_STOP, 8'hFF, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'h2A, 1'b1));
    endtask

    // longest hold on a short operation
    task automatic test_max_hold();
        wait_drained();
        set_hold(16'hFFFF);
        send_op(make_op(i2cmbw_pkg::MODE_START, 8'h3C, 1'b1));
    endtask

    // shortest hold with field extremes and the odd sequences
    task automatic test_min_hold();
        wait_drained();
        set_hold(16'd1);
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'h00, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'hFF, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'h80, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_STOP, 8'h00, 1'b0));
        // write with no start in front, clock line still high
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'h01, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_START, 8'hFF, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_START, 8'h00, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_STOP, 8'hFF, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_STOP, 8'h55, 1'b0));
        // probe address with bit seven set, which is dropped
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'h80, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'hFF, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'h00, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'h7F, 1'b1));
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'h55, 1'b0));
        send_op(make_op(i2cmbw_pkg::MODE_WRITE, 8'hAA, 1'b1));
    endtask

    // mostly well-formed bus traffic, some stray operations, hold changed now and then
    task automatic test_random_traffic(input int target);
        int first;
        int seq;
        int kind;
        first = ops_sent;
        seq   = 0;
        while (ops_sent - first < target) begin
            if (seq % 5 == 0) begin
                wait_drained();
                set_hold(16'($urandom_range(2, 24)));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 9);
            if (kind < 6) begin
                send_transaction($urandom_range(1, 4));
            end else if (kind < 8) begin
                send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1))));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_op(make_op(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                    1'($urandom_range(0, 1))));
            end
            seq++;
        end
    endtask

    // back to back traffic with no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_transaction(3);
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
        send_op(make_op(i2cmbw_pkg::MODE_PROBE, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1))));
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_hold();
        test_max_hold();
        test_min_hold();
        test_random_traffic(75);
        test_steady_stream();
        wait_drained();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2cmbw_pkg.sv
rtl/i2cmbw_ctrl.sv
rtl/i2cmbw_dp.sv
rtl/i2c_master_byte_writer_core.sv
rtl/i2cmbw_checker.sv
sim/i2c_master_byte_writer_core_tb.sv
